FILE: rtl/soss_pkg.sv
package soss_pkg;

    // Field and accumulator widths.
    localparam int SAMPLE_W  = 20;
    localparam int CODE_W    = 16;
    localparam int COUNT_W   = 20;
    localparam int SUM_W     = 42;
    localparam int SQ_W      = 61;
    localparam int MAG_W     = 41;
    localparam int MEAN_W    = 30;
    localparam int SIGMA_W   = 30;
    localparam int DIST_W    = 9;
    localparam int OUTSIDE_W = 20;
    localparam int AXIS_OUT_W = 2;

    // Code window kept per axis, centered on the first code.
    localparam int WINDOW_CODES = 256;
    localparam int WIN_IDX_W    = 8;
    localparam int DIFF_W       = CODE_W + 2;

    // Shared arithmetic unit: wide operand, square root remainder and root.
    localparam int WIDE_W  = 84;
    localparam int ROOT_W  = 43;
    localparam int SQREM_W = 46;
    localparam int STEP_W  = 7;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_FULL = '1;
    localparam logic [SIGMA_W-1:0] SIGMA_MAX  = '1;
    localparam logic [9:0]         MILLI      = 10'd1000;
    localparam logic [19:0]        MICRO      = 20'd1000000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_PUSH   = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ARITH_MUL  = 2'd0,
        ARITH_DIV  = 2'd1,
        ARITH_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_sts_t;

    typedef struct packed {
        opcode_t                     opcode;
        logic signed [SAMPLE_W-1:0]  sample_x;
        logic signed [SAMPLE_W-1:0]  sample_y;
        logic signed [SAMPLE_W-1:0]  sample_z;
    } cmd_t;

endpackage

FILE: rtl/soss_if.sv
interface soss_sample_if;
    logic                    valid;
    logic                    ready;
    soss_pkg::opcode_t       opcode;
    logic signed [19:0]      sample_x;
    logic signed [19:0]      sample_y;
    logic signed [19:0]      sample_z;

    modport source (output valid, opcode, sample_x, sample_y, sample_z, input ready);
    modport sink (input valid, opcode, sample_x, sample_y, sample_z, output ready);
endinterface

interface soss_result_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              axis;
    logic [19:0]             sample_count;
    logic signed [29:0]      mean_milli;
    logic [29:0]             sigma_milli;
    logic signed [15:0]      code_min;
    logic signed [15:0]      code_max;
    logic [8:0]              distinct_codes;
    logic [19:0]             codes_outside;
    logic                    last;

    modport source (output valid, axis, sample_count, mean_milli, sigma_milli, code_min,
                    code_max, distinct_codes, codes_outside, last, input ready);
    modport sink (input valid, axis, sample_count, mean_milli, sigma_milli, code_min,
                  code_max, distinct_codes, codes_outside, last, output ready);
endinterface

FILE: rtl/soss_front.sv
module soss_front (
    input  logic                clk,
    input  logic                rst_n,
    soss_sample_if.sink         samples,
    output soss_pkg::cmd_t      q_word,
    output logic                q_valid,
    input  logic                q_pop
);

    soss_pkg::cmd_t                 slot_reg [soss_pkg::QUEUE_DEPTH];
    logic [soss_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [soss_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [soss_pkg::QPTR_W:0]      fill_reg, fill_next;
    logic                           take;
    logic                           keep;
    logic                           pop;

    // A word with the unused opcode is taken and dropped; it has no effect.
    assign samples.ready = (fill_reg != (soss_pkg::QPTR_W+1)'(soss_pkg::QUEUE_DEPTH));
    assign take          = samples.valid && samples.ready;
    assign keep          = take && (samples.opcode != soss_pkg::OP_NONE);
    assign q_valid       = (fill_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_word        = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = keep ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (soss_pkg::QPTR_W+1)'(keep) - (soss_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            slot_reg[wr_ptr_reg] <= '{opcode:   samples.opcode,
                                      sample_x: samples.sample_x,
                                      sample_y: samples.sample_y,
                                      sample_z: samples.sample_z};
        end
    end

endmodule

FILE: rtl/soss_arith.sv
module soss_arith (
    input  logic                            clk,
    input  logic                            rst_n,
    input  soss_pkg::arith_ctl_t            ctl,
    input  logic [soss_pkg::WIDE_W-1:0]     a,
    input  logic [soss_pkg::WIDE_W-1:0]     b,
    output logic [soss_pkg::WIDE_W-1:0]     result,
    output soss_pkg::arith_sts_t            sts
);

    localparam int W  = soss_pkg::WIDE_W;
    localparam int CW = soss_pkg::COUNT_W;
    localparam int RW = soss_pkg::SQREM_W;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_SQRT = 4'b1000
    } arith_state_t;

    arith_state_t                       state_reg, state_next;
    logic [W-1:0]                       acc_reg, acc_next;
    logic [W-1:0]                       mcand_reg, mcand_next;
    logic [W-1:0]                       mplier_reg, mplier_next;
    logic [CW-1:0]                      rem_reg, rem_next;
    logic [CW-1:0]                      dvsr_reg, dvsr_next;
    logic [RW-1:0]                      sq_rem_reg, sq_rem_next;
    logic [soss_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [soss_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [CW:0]                        div_trial;
    logic                               div_ge;
    logic [RW+1:0]                      sq_trial;
    logic [RW+1:0]                      sq_sub;
    logic                               sq_ge;
    logic                               done;

    // One bit of quotient and one bit of root are formed per cycle.
    assign div_trial = {rem_reg, acc_reg[W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvsr_reg});
    assign sq_trial  = {sq_rem_reg, acc_reg[W-1:W-2]};
    assign sq_sub    = (RW+2)'({root_reg, 2'b01});
    assign sq_ge     = (sq_trial >= sq_sub);

    always_comb
    begin
        unique case (state_reg)
            A_MUL:   done = (mplier_reg == '0);
            A_DIV,
            A_SQRT:  done = (step_reg == '0);
            default: done = 1'b0;
        endcase
    end

    assign sts.done = done;
    assign sts.busy = (state_reg != A_IDLE);
    assign result   = (state_reg == A_SQRT) ? W'(root_reg) : acc_reg;

    // Sequencer for the shift-add multiply, restoring divide and digit square root.
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        sq_rem_next = sq_rem_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (ctl.start)
                begin
                    unique case (ctl.op)
                        soss_pkg::ARITH_MUL:
                        begin
                            acc_next    = '0;
                            mcand_next  = a;
                            mplier_next = b;
                            state_next  = A_MUL;
                        end
                        soss_pkg::ARITH_DIV:
                        begin
                            acc_next   = a;
                            rem_next   = '0;
                            dvsr_next  = b[CW-1:0];
                            step_next  = soss_pkg::STEP_W'(W);
                            state_next = A_DIV;
                        end
                        soss_pkg::ARITH_SQRT:
                        begin
                            acc_next    = a;
                            sq_rem_next = '0;
                            root_next   = '0;
                            step_next   = soss_pkg::STEP_W'(W / 2);
                            state_next  = A_SQRT;
                        end
                        default:
                        begin
                            state_next = A_IDLE;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                if (done)
                begin
                    state_next = A_IDLE;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[W-1:1]};
                end
            end
            A_DIV:
            begin
                if (done)
                begin
                    state_next = A_IDLE;
                end
                else
                begin
                    rem_next  = div_ge ? CW'(div_trial - {1'b0, dvsr_reg}) : div_trial[CW-1:0];
                    acc_next  = {acc_reg[W-2:0], div_ge};
                    step_next = step_reg - 1'b1;
                end
            end
            A_SQRT:
            begin
                if (done)
                begin
                    state_next = A_IDLE;
                end
                else
                begin
                    sq_rem_next = sq_ge ? RW'(sq_trial - sq_sub) : sq_trial[RW-1:0];
                    root_next   = {root_reg[soss_pkg::ROOT_W-2:0], sq_ge};
                    acc_next    = {acc_reg[W-3:0], 2'b00};
                    step_next   = step_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
        sq_rem_reg <= sq_rem_next;
        root_reg   <= root_next;
    end

endmodule

FILE: rtl/soss_back.sv
module soss_back #(
    parameter int AXES = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  soss_pkg::cmd_t      q_word,
    input  logic                q_valid,
    output logic                q_pop,
    soss_result_if.source       results
);

    localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SW     = soss_pkg::SAMPLE_W;
    localparam int CDW    = soss_pkg::CODE_W;
    localparam int NW     = soss_pkg::COUNT_W;
    localparam int W      = soss_pkg::WIDE_W;
    localparam int IW     = soss_pkg::WIN_IDX_W;
    localparam int DW     = soss_pkg::DIFF_W;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

    typedef enum logic [12:0] {
        B_CLEAR    = 13'd1,
        B_IDLE     = 13'd2,
        B_PUSH_A   = 13'd4,
        B_PUSH_B   = 13'd8,
        B_REP_LOAD = 13'd16,
        B_MEAN_MUL = 13'd32,
        B_MEAN_DIV = 13'd64,
        B_SQ_MUL   = 13'd128,
        B_SQ_DIV   = 13'd256,
        B_VAR_MUL  = 13'd512,
        B_VAR_DIV  = 13'd1024,
        B_SQRT     = 13'd2048,
        B_EMIT     = 13'd4096
    } back_state_t;

    back_state_t                        state_reg, state_next;
    soss_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [IW-1:0]                      clr_ptr_reg, clr_ptr_next;

    // Per-axis statistics.
    logic [NW-1:0]                      count_reg       [AXES];
    logic signed [SW-1:0]               first_sample_reg[AXES];
    logic signed [CDW-1:0]              first_code_reg  [AXES];
    logic signed [soss_pkg::SUM_W-1:0]  offset_total_reg[AXES];
    logic [soss_pkg::SQ_W-1:0]          sq_total_reg    [AXES];
    logic signed [CDW-1:0]              lowest_reg      [AXES];
    logic signed [CDW-1:0]              highest_reg     [AXES];
    logic [soss_pkg::DIST_W-1:0]        distinct_reg    [AXES];
    logic [soss_pkg::OUTSIDE_W-1:0]     outside_reg     [AXES];

    // Push staging between the map read and the update.
    logic signed [SW:0]                 d_reg     [AXES];
    logic signed [CDW-1:0]              code_reg  [AXES];
    logic [IW-1:0]                      idx_reg   [AXES];
    logic                               inside_reg[AXES];
    logic                               skip_reg  [AXES];
    logic                               seen_reg  [AXES];

    logic                               map_mem [AXES][soss_pkg::WINDOW_CODES];

    // Push decode, one set per axis.
    logic signed [SW-1:0]               smp      [AXES];
    logic signed [CDW-1:0]              smp_code [AXES];
    logic                               is_first [AXES];
    logic signed [SW:0]                 smp_d    [AXES];
    logic signed [DW-1:0]               smp_diff [AXES];
    logic                               smp_in   [AXES];
    logic [SW:0]                        d_mag    [AXES];
    logic [2*SW+1:0]                    d_sq     [AXES];

    // Report datapath.
    logic [AXIS_W-1:0]                  axis_reg, axis_next;
    logic [NW-1:0]                      n_reg, n_next;
    logic [soss_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic                               neg_reg, neg_next;
    logic [soss_pkg::MEAN_W-1:0]        mean_reg, mean_next;
    logic [soss_pkg::SIGMA_W-1:0]       sigma_reg, sigma_next;
    logic [W-1:0]                       wide_reg, wide_next;
    logic                               issued_reg, issued_next;
    logic signed [soss_pkg::SUM_W-1:0]  load_total;
    logic [soss_pkg::SUM_W-1:0]         load_mag;
    logic signed [30:0]                 origin_milli;
    logic [soss_pkg::MEAN_W-1:0]        q_low;
    logic [W-1:0]                       sq_ext;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    logic                               out_space;
    logic                               out_load;

    soss_pkg::arith_ctl_t               arith_ctl;
    soss_pkg::arith_sts_t               arith_sts;
    logic [W-1:0]                       arith_a;
    logic [W-1:0]                       arith_b;
    logic [W-1:0]                       arith_result;
    logic                               computing;
    logic                               clear_stats;
    logic                               push_a;
    logic                               push_b;

    soss_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (arith_ctl),
        .a      (arith_a),
        .b      (arith_b),
        .result (arith_result),
        .sts    (arith_sts)
    );

    assign q_pop       = (state_reg == B_IDLE) && q_valid;
    assign clear_stats = q_pop && (q_word.opcode == soss_pkg::OP_CLEAR);
    assign push_a      = (state_reg == B_PUSH_A);
    assign push_b      = (state_reg == B_PUSH_B);
    assign out_space   = !out_valid_reg || results.ready;
    assign out_load    = (state_reg == B_EMIT) && out_space;

    // Push decode: offset from the origin and place of the code in the window.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (a % 3 == 0)
            begin
                smp[a] = cmd_reg.sample_x;
            end
            else if (a % 3 == 1)
            begin
                smp[a] = cmd_reg.sample_y;
            end
            else
            begin
                smp[a] = cmd_reg.sample_z;
            end
            smp_code[a] = smp[a][SW-1:SW-CDW];
            is_first[a] = (count_reg[a] == '0);
            smp_d[a]    = is_first[a] ? '0
                        : ($signed({smp[a][SW-1], smp[a]})
                           - $signed({first_sample_reg[a][SW-1], first_sample_reg[a]}));
            smp_diff[a] = is_first[a] ? DW'(soss_pkg::WINDOW_CODES / 2)
                        : ($signed({{2{smp_code[a][CDW-1]}}, smp_code[a]})
                           - $signed({{2{first_code_reg[a][CDW-1]}}, first_code_reg[a]})
                           + $signed(DW'(soss_pkg::WINDOW_CODES / 2)));
            smp_in[a]   = !smp_diff[a][DW-1]
                        && (smp_diff[a] < $signed(DW'(soss_pkg::WINDOW_CODES)));
            d_mag[a]    = d_reg[a][SW] ? (SW+1)'(-d_reg[a]) : d_reg[a];
            d_sq[a]     = d_mag[a] * d_mag[a];
        end
    end

    // Statistics update: clear, first-sample capture and accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                count_reg[a]        <= '0;
                first_sample_reg[a] <= '0;
                first_code_reg[a]   <= '0;
                offset_total_reg[a] <= '0;
                sq_total_reg[a]     <= '0;
                lowest_reg[a]       <= '0;
                highest_reg[a]      <= '0;
                distinct_reg[a]     <= '0;
                outside_reg[a]      <= '0;
                skip_reg[a]         <= 1'b1;
            end
        end
        else if (clear_stats)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                count_reg[a]        <= '0;
                first_sample_reg[a] <= '0;
                first_code_reg[a]   <= '0;
                offset_total_reg[a] <= '0;
                sq_total_reg[a]     <= '0;
                lowest_reg[a]       <= '0;
                highest_reg[a]      <= '0;
                distinct_reg[a]     <= '0;
                outside_reg[a]      <= '0;
            end
        end
        else if (push_a)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                skip_reg[a] <= (count_reg[a] == soss_pkg::COUNT_FULL);
                if (is_first[a])
                begin
                    first_sample_reg[a] <= smp[a];
                    first_code_reg[a]   <= smp_code[a];
                    lowest_reg[a]       <= smp_code[a];
                    highest_reg[a]      <= smp_code[a];
                end
            end
        end
        else if (push_b)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (!skip_reg[a])
                begin
                    count_reg[a]        <= count_reg[a] + 1'b1;
                    offset_total_reg[a] <= offset_total_reg[a]
                                         + soss_pkg::SUM_W'(d_reg[a]);
                    sq_total_reg[a]     <= sq_total_reg[a]
                                         + soss_pkg::SQ_W'(d_sq[a]);
                    if (code_reg[a] < lowest_reg[a])
                    begin
                        lowest_reg[a] <= code_reg[a];
                    end
                    if (code_reg[a] > highest_reg[a])
                    begin
                        highest_reg[a] <= code_reg[a];
                    end
                    if (inside_reg[a])
                    begin
                        if (!seen_reg[a])
                        begin
                            distinct_reg[a] <= distinct_reg[a] + 1'b1;
                        end
                    end
                    else
                    begin
                        outside_reg[a] <= outside_reg[a] + 1'b1;
                    end
                end
            end
        end
    end

    // Push staging registers.
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                d_reg[a]      <= smp_d[a];
                code_reg[a]   <= smp_code[a];
                idx_reg[a]    <= smp_diff[a][IW-1:0];
                inside_reg[a] <= smp_in[a];
            end
        end
    end

    // Code map: cleared by a sweep, read in B_PUSH_A, set in B_PUSH_B.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (state_reg == B_CLEAR)
            begin
                map_mem[a][clr_ptr_reg] <= 1'b0;
            end
            else if (push_b && !skip_reg[a] && inside_reg[a] && !seen_reg[a])
            begin
                map_mem[a][idx_reg[a]] <= 1'b1;
            end
            if (push_a)
            begin
                seen_reg[a] <= map_mem[a][smp_diff[a][IW-1:0]];
            end
        end
    end

    // Operands for the shared arithmetic unit.
    always_comb
    begin
        computing     = 1'b1;
        arith_ctl.op  = soss_pkg::ARITH_MUL;
        arith_a       = W'(mag_reg);
        arith_b       = W'(soss_pkg::MILLI);
        unique case (state_reg)
            B_MEAN_MUL:
            begin
                arith_ctl.op = soss_pkg::ARITH_MUL;
            end
            B_MEAN_DIV:
            begin
                arith_ctl.op = soss_pkg::ARITH_DIV;
                arith_a      = wide_reg;
                arith_b      = W'(n_reg);
            end
            B_SQ_MUL:
            begin
                arith_ctl.op = soss_pkg::ARITH_MUL;
                arith_b      = W'(mag_reg);
            end
            B_SQ_DIV:
            begin
                arith_ctl.op = soss_pkg::ARITH_DIV;
                arith_a      = wide_reg;
                arith_b      = W'(n_reg);
            end
            B_VAR_MUL:
            begin
                arith_ctl.op = soss_pkg::ARITH_MUL;
                arith_a      = wide_reg;
                arith_b      = W'(soss_pkg::MICRO);
            end
            B_VAR_DIV:
            begin
                arith_ctl.op = soss_pkg::ARITH_DIV;
                arith_a      = wide_reg;
                arith_b      = W'(n_reg - 1'b1);
            end
            B_SQRT:
            begin
                arith_ctl.op = soss_pkg::ARITH_SQRT;
                arith_a      = wide_reg;
            end
            default:
            begin
                computing = 1'b0;
            end
        endcase
        arith_ctl.start = computing && !issued_reg;
    end

    assign load_total   = offset_total_reg[axis_reg];
    assign load_mag     = load_total[soss_pkg::SUM_W-1] ? soss_pkg::SUM_W'(-load_total)
                                                        : load_total;
    assign origin_milli = $signed(31'(first_sample_reg[axis_reg]))
                        * $signed(31'(soss_pkg::MILLI));
    assign q_low        = arith_result[soss_pkg::MEAN_W-1:0];
    assign sq_ext       = W'(sq_total_reg[axis_reg]);

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        clr_ptr_next = clr_ptr_reg;
        axis_next    = axis_reg;
        n_next       = n_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        mean_next    = mean_reg;
        sigma_next   = sigma_reg;
        wide_next    = wide_reg;
        issued_next  = issued_reg;
        if (computing)
        begin
            if (!issued_reg)
            begin
                issued_next = 1'b1;
            end
            else if (arith_sts.done)
            begin
                issued_next = 1'b0;
                wide_next   = arith_result;
            end
        end
        unique case (state_reg)
            B_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == IW'(soss_pkg::WINDOW_CODES - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_word;
                    priority case (q_word.opcode)
                        soss_pkg::OP_CLEAR:
                        begin
                            clr_ptr_next = '0;
                            state_next   = B_CLEAR;
                        end
                        soss_pkg::OP_PUSH:
                        begin
                            state_next = B_PUSH_A;
                        end
                        soss_pkg::OP_REPORT:
                        begin
                            axis_next  = '0;
                            state_next = B_REP_LOAD;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_PUSH_A:
            begin
                state_next = B_PUSH_B;
            end
            B_PUSH_B:
            begin
                state_next = B_IDLE;
            end
            B_REP_LOAD:
            begin
                n_next     = count_reg[axis_reg];
                mag_next   = load_mag[soss_pkg::MAG_W-1:0];
                neg_next   = load_total[soss_pkg::SUM_W-1];
                mean_next  = '0;
                sigma_next = '0;
                state_next = (count_reg[axis_reg] == '0) ? B_EMIT : B_MEAN_MUL;
            end
            B_MEAN_MUL:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    state_next = B_MEAN_DIV;
                end
            end
            B_MEAN_DIV:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    mean_next  = origin_milli[soss_pkg::MEAN_W-1:0]
                               + (neg_reg ? soss_pkg::MEAN_W'(-q_low) : q_low);
                    state_next = (n_reg < NW'(2)) ? B_EMIT : B_SQ_MUL;
                end
            end
            B_SQ_MUL:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    state_next = B_SQ_DIV;
                end
            end
            B_SQ_DIV:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    // Negative numerator from rounding clamps at zero.
                    wide_next  = (arith_result > sq_ext) ? '0 : sq_ext - arith_result;
                    state_next = B_VAR_MUL;
                end
            end
            B_VAR_MUL:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    state_next = B_VAR_DIV;
                end
            end
            B_VAR_DIV:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (issued_reg && arith_sts.done)
                begin
                    sigma_next = (arith_result > W'(soss_pkg::SIGMA_MAX))
                               ? soss_pkg::SIGMA_MAX
                               : arith_result[soss_pkg::SIGMA_W-1:0];
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_space)
                begin
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = B_REP_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_ptr_reg <= '0;
            axis_reg    <= '0;
            issued_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            axis_reg    <= axis_next;
            issued_reg  <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        n_reg     <= n_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        mean_reg  <= mean_next;
        sigma_reg <= sigma_next;
        wide_reg  <= wide_next;
    end

    // Result word register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            results.axis           <= soss_pkg::AXIS_OUT_W'(axis_reg);
            results.sample_count   <= n_reg;
            results.mean_milli     <= $signed(mean_reg);
            results.sigma_milli    <= sigma_reg;
            results.code_min       <= lowest_reg[axis_reg];
            results.code_max       <= highest_reg[axis_reg];
            results.distinct_codes <= distinct_reg[axis_reg];
            results.codes_outside  <= outside_reg[axis_reg];
            results.last           <= (axis_reg == AXIS_LAST);
        end
    end

    assign results.valid = out_valid_reg;

endmodule

FILE: rtl/shifted_origin_sample_statistics_unit.sv
// Running mean and sample standard deviation of three-axis 20-bit samples.
//
// The samples channel takes one word per handshake: opcode clear, push or
// report, with one signed sample per axis. The results channel gives one word
// per axis for each report, with last set on the final axis.
// Words enter a four-deep queue, so until it fills the sender is not held while
// the engine behind it works or while a result waits in the output register.
// A push passes through the idle state and both push states of the engine, which
// takes no new word until it is back in idle. A clear sweeps the 256-entry code
// map of every axis, one entry per cycle; reset starts the same sweep, and
// queued words wait behind it.
// A report runs a shift-add multiplier, a one-bit-per-cycle divider and a
// two-bits-per-cycle square root in sequence for each axis; axes with fewer
// than two samples skip the spread steps, and an empty axis skips every step.
// When the receiver stalls, the result word holds and the engine waits with
// the next one; the queue keeps taking words until it is full.
// An opcode of three is taken and has no effect.
module shifted_origin_sample_statistics_unit #(
    parameter int AXES = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    soss_sample_if.sink     samples,
    soss_result_if.source   results
);

    soss_pkg::cmd_t q_word;
    logic           q_valid;
    logic           q_pop;

    soss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_word  (q_word),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    soss_back #(
        .AXES (AXES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_word  (q_word),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

FILE: rtl/soss_checker.sv
module soss_checker #(
    parameter int AXES = 3
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           axis,
    input logic [19:0]          sample_count,
    input logic signed [29:0]   mean_milli,
    input logic [29:0]          sigma_milli,
    input logic                 last
);

    localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

    // A stalled result word keeps its axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(axis))
        else $error("result word changed while stalled");

    // The final word of a report belongs to the last axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> axis == AXIS_LAST)
        else $error("last flag on a word that is not the last axis");

    // Fewer than two samples give no spread.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_count < 20'd2 |-> sigma_milli == '0)
        else $error("nonzero sigma with fewer than two samples");

    // An empty axis reports a zero mean.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_count == '0 |-> mean_milli == '0)
        else $error("nonzero mean on an empty axis");

endmodule

bind shifted_origin_sample_statistics_unit soss_checker #(
    .AXES (AXES)
) u_soss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .axis         (results.axis),
    .sample_count (results.sample_count),
    .mean_milli   (results.mean_milli),
    .sigma_milli  (results.sigma_milli),
    .last         (results.last)
);

FILE: test/tb.sv
module tb;

    localparam int NUM_AXES = 3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 185;

    typedef struct {
        logic [1:0]         axis;
        logic [19:0]        sample_count;
        logic signed [29:0] mean_milli;
        logic [29:0]        sigma_milli;
        logic signed [15:0] code_min;
        logic signed [15:0] code_max;
        logic [8:0]         distinct_codes;
        logic [19:0]        codes_outside;
        logic               last;
    } axis_stats_t;

    typedef struct {
        soss_pkg::opcode_t  op;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        bit                 expect_empty;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    int   quiet_cycles = 0;
    bit   no_idle = 1'b0;

    soss_sample_if samples ();
    soss_result_if results ();

    shifted_origin_sample_statistics_unit #(.AXES(NUM_AXES)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples),
        .results(results)
    );

    // Mirror of the per-axis accumulator state.
    logic [19:0]        acc_count [NUM_AXES];
    logic signed [63:0] acc_origin [NUM_AXES];
    logic signed [15:0] acc_first_code [NUM_AXES];
    logic signed [63:0] acc_sum [NUM_AXES];
    logic [60:0]        acc_sq [NUM_AXES];
    logic signed [15:0] acc_low [NUM_AXES];
    logic signed [15:0] acc_high [NUM_AXES];
    logic [8:0]         acc_distinct [NUM_AXES];
    logic [19:0]        acc_outside [NUM_AXES];
    bit                 acc_map [NUM_AXES][soss_pkg::WINDOW_CODES];

    axis_stats_t pending_stats [$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic clear_stats();
        for (int a = 0; a < NUM_AXES; a++)
        begin
            acc_count[a] = '0;
            acc_origin[a] = '0;
            acc_first_code[a] = '0;
            acc_sum[a] = '0;
            acc_sq[a] = '0;
            acc_low[a] = '0;
            acc_high[a] = '0;
            acc_distinct[a] = '0;
            acc_outside[a] = '0;
            for (int i = 0; i < soss_pkg::WINDOW_CODES; i++)
                acc_map[a][i] = 1'b0;
        end
    endtask

    // Add one sample to an axis, relative to the origin of that axis.
    task automatic add_sample(int a, logic signed [19:0] s);
        logic signed [63:0] v;
        logic signed [15:0] code;
        logic signed [63:0] d;
        logic [63:0]        mag;
        int                 idx;
        v = s;
        code = s >>> 4;
        if (acc_count[a] == soss_pkg::COUNT_FULL)
            return;
        if (acc_count[a] == 0)
        begin
            acc_origin[a] = v;
            acc_first_code[a] = code;
            acc_low[a] = code;
            acc_high[a] = code;
        end
        d = v - acc_origin[a];
        mag = (d < 0) ? -d : d;
        acc_sum[a] += d;
        acc_sq[a] = acc_sq[a] + 61'(mag * mag);
        acc_count[a]++;
        if (code < acc_low[a])
            acc_low[a] = code;
        if (code > acc_high[a])
            acc_high[a] = code;
        idx = int'(code) - int'(acc_first_code[a]) + soss_pkg::WINDOW_CODES / 2;
        if (idx >= 0 && idx < soss_pkg::WINDOW_CODES)
        begin
            if (!acc_map[a][idx])
            begin
                acc_map[a][idx] = 1'b1;
                acc_distinct[a]++;
            end
        end
        else
            acc_outside[a]++;
    endtask

    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] c2;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            c2 = {64'd0, c} * {64'd0, c};
            if (c2 <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic axis_stats_t axis_report(int a);
        axis_stats_t  o;
        logic [127:0] n;
        logic [127:0] m;
        logic [127:0] q;
        logic [127:0] num;
        logic [127:0] scaled;
        logic [63:0]  root;
        logic signed [63:0] s;
        logic [63:0]  sq_mag;
        logic signed [63:0] mean;
        n = acc_count[a];
        o.axis = a[1:0];
        o.sample_count = acc_count[a];
        o.code_min = acc_low[a];
        o.code_max = acc_high[a];
        o.distinct_codes = acc_distinct[a];
        o.codes_outside = acc_outside[a];
        o.last = (a == NUM_AXES - 1);
        if (n == 0)
            o.mean_milli = '0;
        else
        begin
            s = acc_sum[a] * 1000;
            sq_mag = (s < 0) ? -s : s;
            sq_mag = sq_mag / n[63:0];
            mean = acc_origin[a] * 1000 + ((s < 0) ? -$signed(sq_mag) : $signed(sq_mag));
            o.mean_milli = mean[29:0];
        end
        if (n < 2)
            o.sigma_milli = '0;
        else
        begin
            m = (acc_sum[a] < 0) ? -acc_sum[a] : acc_sum[a];
            m = {64'd0, m[63:0]};
            q = (m * m) / n;
            num = (q > {67'd0, acc_sq[a]}) ? 128'd0 : {67'd0, acc_sq[a]} - q;
            scaled = (num * 128'd1000000) / (n - 1);
            root = floor_root(scaled);
            o.sigma_milli = (root > 64'(soss_pkg::SIGMA_MAX)) ? soss_pkg::SIGMA_MAX
                                                              : root[29:0];
        end
        return o;
    endfunction

    // Update the mirror for one accepted word and queue what it should produce.
    task automatic apply_word(soss_pkg::opcode_t op, logic signed [19:0] x,
                              logic signed [19:0] y, logic signed [19:0] z,
                              bit literal_empty);
        axis_stats_t e;
        case (op)
            soss_pkg::OP_CLEAR: clear_stats();
            soss_pkg::OP_PUSH:
            begin
                add_sample(0, x);
                add_sample(1, y);
                add_sample(2, z);
            end
            soss_pkg::OP_REPORT:
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    if (literal_empty)
                    begin
                        e = '{a[1:0], 20'd0, 30'sd0, 30'd0, 16'sd0, 16'sd0, 9'd0, 20'd0,
                              a == NUM_AXES - 1};
                    end
                    else
                        e = axis_report(a);
                    pending_stats.push_back(e);
                end
            default: ;
        endcase
    endtask

    task automatic send_word(soss_pkg::opcode_t op, logic signed [19:0] x,
                             logic signed [19:0] y, logic signed [19:0] z,
                             bit literal_empty);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < 7)
                gap++;
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.opcode <= op;
        samples.sample_x <= x;
        samples.sample_y <= y;
        samples.sample_z <= z;
        do
            @(posedge clk);
        while (!samples.ready);
        apply_word(op, x, y, z, literal_empty);
    endtask

    function automatic logic signed [19:0] near(logic signed [19:0] base, int spread);
        return 20'(int'(base) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Receiver side: random stalls, with a quiet stretch in the middle of the run.
    always @(posedge clk)
    begin
        if (no_idle)
            results.ready <= 1'b1;
        else
            results.ready <= ($urandom_range(0, 99) >= 7);
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        axis_stats_t e;
        if (rst_n)
        begin
            if ((samples.valid && samples.ready) || (results.valid && results.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            if (results.valid && results.ready)
            begin
                if (pending_stats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word for axis %0d", $time, results.axis);
                end
                else
                begin
                    e = pending_stats.pop_front();
                    if (results.axis !== e.axis || results.sample_count !== e.sample_count ||
                        results.mean_milli !== e.mean_milli ||
                        results.sigma_milli !== e.sigma_milli ||
                        results.code_min !== e.code_min || results.code_max !== e.code_max ||
                        results.distinct_codes !== e.distinct_codes ||
                        results.codes_outside !== e.codes_outside || results.last !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected axis=%0d n=%0d mean=%0d sigma=%0d",
                                 $time, e.axis, e.sample_count, e.mean_milli, e.sigma_milli);
                        $display("      min=%0d max=%0d distinct=%0d outside=%0d last=%0d",
                                 e.code_min, e.code_max, e.distinct_codes, e.codes_outside,
                                 e.last);
                        $display("  actual axis=%0d n=%0d mean=%0d sigma=%0d",
                                 results.axis, results.sample_count, results.mean_milli,
                                 results.sigma_milli);
                        $display("      min=%0d max=%0d distinct=%0d outside=%0d last=%0d",
                                 results.code_min, results.code_max, results.distinct_codes,
                                 results.codes_outside, results.last);
                    end
                end
            end
        end
    end

    stim_row_t directed [] = '{
        '{soss_pkg::OP_REPORT, 20'sd0, 20'sd0, 20'sd0, 1'b1},
        '{soss_pkg::OP_PUSH, 20'sh7FFFF, -20'sd524288, 20'sd0, 1'b0},
        '{soss_pkg::OP_REPORT, 20'sd0, 20'sd0, 20'sd0, 1'b0},
        '{soss_pkg::OP_PUSH, -20'sd524288, 20'sh7FFFF, 20'sd15, 1'b0},
        '{soss_pkg::OP_PUSH, 20'sd0, 20'sd0, -20'sd16, 1'b0},
        '{soss_pkg::OP_NONE, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b0},
        '{soss_pkg::OP_REPORT, 20'sd0, 20'sd0, 20'sd0, 1'b0},
        '{soss_pkg::OP_CLEAR, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b0},
        '{soss_pkg::OP_REPORT, -20'sd1, -20'sd1, -20'sd1, 1'b1},
        '{soss_pkg::OP_PUSH, -20'sd1, 20'sd2047, -20'sd2048, 1'b0},
        '{soss_pkg::OP_PUSH, -20'sd1, 20'sd2048, -20'sd2049, 1'b0},
        '{soss_pkg::OP_PUSH, 20'sd16, -20'sd2048, 20'sd2047, 1'b0},
        '{soss_pkg::OP_PUSH, -20'sd17, 20'sd100, 20'sd5, 1'b0},
        '{soss_pkg::OP_REPORT, 20'sd0, 20'sd0, 20'sd0, 1'b0},
        '{soss_pkg::OP_PUSH, 20'sd33, 20'sh55555, -20'sd349526, 1'b0},
        '{soss_pkg::OP_PUSH, -20'sd40, 20'sd7, 20'sd3, 1'b0},
        '{soss_pkg::OP_REPORT, 20'sd0, 20'sd0, 20'sd0, 1'b0},
        '{soss_pkg::OP_CLEAR, 20'sd0, 20'sd0, 20'sd0, 1'b0},
        '{soss_pkg::OP_PUSH, 20'sd5, 20'sd5, 20'sd5, 1'b0},
        '{soss_pkg::OP_PUSH, 20'sd5, 20'sd5, 20'sd5, 1'b0},
        '{soss_pkg::OP_REPORT, 20'sd0, 20'sd0, 20'sd0, 1'b0},
        '{soss_pkg::OP_CLEAR, 20'sd0, 20'sd0, 20'sd0, 1'b0}
    };

    initial
    begin
        logic signed [19:0] base [3];
        int spread;
        int pick;
        soss_pkg::opcode_t op;
        samples.valid = 1'b0;
        samples.opcode = soss_pkg::OP_NONE;
        samples.sample_x = '0;
        samples.sample_y = '0;
        samples.sample_z = '0;
        results.ready = 1'b0;
        clear_stats();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        foreach (directed[i])
            send_word(directed[i].op, directed[i].x, directed[i].y, directed[i].z,
                      directed[i].expect_empty);

        // Random part: mostly pushes around a per-axis center, with reports, clears and unused opcodes sprinkled in.
        for (int k = 0; k < 3; k++)
            base[k] = 20'($urandom());
        spread = 1500;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 70 && i < 120);
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                op = soss_pkg::OP_CLEAR;
                for (int k = 0; k < 3; k++)
                    base[k] = 20'($urandom());
                spread = ($urandom_range(0, 1) != 0) ? 1500 : 40;
            end
            else if (pick < 14)
                op = soss_pkg::OP_REPORT;
            else if (pick < 17)
                op = soss_pkg::OP_NONE;
            else
                op = soss_pkg::OP_PUSH;
            if (op == soss_pkg::OP_PUSH && $urandom_range(0, 9) == 0)
                send_word(op, 20'($urandom()), 20'($urandom()), 20'($urandom()), 1'b0);
            else
                send_word(op, near(base[0], spread), near(base[1], spread),
                          near(base[2], spread), 1'b0);
        end
        send_word(soss_pkg::OP_REPORT, '0, '0, '0, 1'b0);
        samples.valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: shifted_origin_sample_statistics_unit.f
rtl/soss_pkg.sv
rtl/soss_if.sv
rtl/soss_front.sv
rtl/soss_arith.sv
rtl/soss_back.sv
rtl/shifted_origin_sample_statistics_unit.sv
rtl/soss_checker.sv
test/tb.sv
